FILE: sv/tcgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, codes and the 8x8 font table of the glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_HEIGHT_DEF = 128;

    localparam int unsigned GLYPH_COUNT = 42;
    localparam int unsigned GLYPH_W     = 6;
    localparam int unsigned ROM_DEPTH   = GLYPH_COUNT * 8;
    localparam int unsigned CFG_IDX_W   = 2;

    typedef logic [GLYPH_W-1:0] glyph_t;
    typedef logic [63:0]        glyph_bits_t;

    // request codes
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

    localparam logic [2:0] FG_RESET = 3'd1;
    localparam logic [2:0] BG_RESET = 3'd0;

    // character codes and glyph slots
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] DIGIT_BIAS = 8'd22;
    localparam logic [7:0] CH_PERIOD  = 8'd46;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_BANG    = 8'd33;
    localparam logic [7:0] CH_DASH    = 8'd45;
    localparam logic [7:0] CH_UNDER   = 8'd95;

    localparam glyph_t GLYPH_PERIOD = 6'd36;
    localparam glyph_t GLYPH_COLON  = 6'd37;
    localparam glyph_t GLYPH_BANG   = 6'd38;
    localparam glyph_t GLYPH_DASH   = 6'd39;
    localparam glyph_t GLYPH_UNDER  = 6'd40;
    localparam glyph_t GLYPH_BLANK  = 6'd41;

    // Row bytes, eight per glyph, top row first; bit 0 is the leftmost pixel.
    localparam logic [7:0] FONT_ROM [ROM_DEPTH] = '{
        8'h04, 8'h0a, 8'h0a, 8'h0a, 8'h1f, 8'h11, 8'h11, 8'h11,
        8'h07, 8'h09, 8'h09, 8'h09, 8'h0f, 8'h11, 8'h11, 8'h0f,
        8'h0e, 8'h11, 8'h01, 8'h01, 8'h01, 8'h01, 8'h11, 8'h0e,
        8'h07, 8'h09, 8'h11, 8'h11, 8'h11, 8'h11, 8'h09, 8'h07,
        8'h1f, 8'h01, 8'h01, 8'h01, 8'h0f, 8'h01, 8'h01, 8'h1f,
        8'h1f, 8'h01, 8'h01, 8'h01, 8'h0f, 8'h01, 8'h01, 8'h01,
        8'h0e, 8'h11, 8'h01, 8'h01, 8'h19, 8'h11, 8'h11, 8'h0e,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h1f, 8'h11, 8'h11, 8'h11,
        8'h1f, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h1f,
        8'h1f, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h09, 8'h06,
        8'h11, 8'h09, 8'h05, 8'h03, 8'h07, 8'h09, 8'h11, 8'h11,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h1f,
        8'h11, 8'h1b, 8'h15, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
        8'h11, 8'h11, 8'h13, 8'h15, 8'h15, 8'h19, 8'h11, 8'h11,
        8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e,
        8'h0f, 8'h11, 8'h11, 8'h11, 8'h0f, 8'h01, 8'h01, 8'h01,
        8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h09, 8'h16,
        8'h0f, 8'h11, 8'h11, 8'h11, 8'h0f, 8'h09, 8'h11, 8'h11,
        8'h0e, 8'h11, 8'h01, 8'h01, 8'h0e, 8'h10, 8'h11, 8'h0e,
        8'h1f, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e,
        8'h11, 8'h11, 8'h11, 8'h0a, 8'h0a, 8'h0a, 8'h04, 8'h04,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h15, 8'h15, 8'h15, 8'h0a,
        8'h11, 8'h11, 8'h0a, 8'h04, 8'h04, 8'h0a, 8'h11, 8'h11,
        8'h11, 8'h11, 8'h11, 8'h0a, 8'h04, 8'h04, 8'h04, 8'h04,
        8'h1f, 8'h10, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h1f,
        8'h0e, 8'h11, 8'h15, 8'h15, 8'h15, 8'h15, 8'h11, 8'h0e,
        8'h06, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h1f,
        8'h0e, 8'h11, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h1f,
        8'h1f, 8'h10, 8'h08, 8'h04, 8'h08, 8'h10, 8'h11, 8'h0e,
        8'h10, 8'h11, 8'h11, 8'h11, 8'h1f, 8'h10, 8'h10, 8'h10,
        8'h1f, 8'h11, 8'h01, 8'h01, 8'h0e, 8'h10, 8'h11, 8'h0e,
        8'h0e, 8'h11, 8'h01, 8'h01, 8'h0f, 8'h11, 8'h11, 8'h0e,
        8'h1f, 8'h11, 8'h10, 8'h08, 8'h04, 8'h04, 8'h04, 8'h04,
        8'h0e, 8'h11, 8'h11, 8'h0e, 8'h11, 8'h11, 8'h11, 8'h0e,
        8'h0e, 8'h11, 8'h11, 8'h1e, 8'h10, 8'h10, 8'h10, 8'h10,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04,
        8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00,
        8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00, 8'h04,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h0e, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1f,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic glyph_t glyph_of(input logic [7:0] code);
        glyph_t g;
        g = GLYPH_BLANK;
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z)
            g = GLYPH_W'(code - CH_LOWER_A);
        else if (code >= CH_UPPER_A && code <= CH_UPPER_Z)
            g = GLYPH_W'(code - CH_UPPER_A);
        else if (code >= CH_ZERO && code <= CH_NINE)
            g = GLYPH_W'(code - DIGIT_BIAS);
        else if (code == CH_PERIOD)
            g = GLYPH_PERIOD;
        else if (code == CH_COLON)
            g = GLYPH_COLON;
        else if (code == CH_BANG)
            g = GLYPH_BANG;
        else if (code == CH_DASH)
            g = GLYPH_DASH;
        else if (code == CH_UNDER)
            g = GLYPH_UNDER;
        return g;
    endfunction

endpackage

FILE: sv/text_cursor_glyph_renderer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer_core
// 8x8 text-mode character generator with a wrapping text cursor.
// ----------------------------------------------------------------------------
// A draw request produces 64 pixel transfers, one per cycle when the sink is
// ready; back-to-back draws stream without gaps because the next glyph waits
// in a one-deep slot and is loaded on the cycle of the previous glyph's last
// pixel. The first pixel of a draw reaches the outputs through the font ROM
// read into the slot at its transfer, then the engine load, then the output
// register. A move request only sets the cursor and emits nothing. The input
// channel stalls only while a draw waits in the slot.
// Colors are sampled per pixel, so write them only while the block is idle.
module text_cursor_glyph_renderer_core
    import tcgr_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [2:0]           cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [7:0]           char_code,
    input  logic [7:0]           move_x,
    input  logic [7:0]           move_y,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           pix_x,
    output logic [7:0]           pix_y,
    output logic [2:0]           pix_color,
    output logic                 last
);

    localparam logic [8:0] X_LIMIT = 9'(SCREEN_WIDTH - 8);
    localparam logic [8:0] Y_LIMIT = 9'(SCREEN_HEIGHT - 8);

    logic [2:0]  fg_reg, bg_reg;
    logic [7:0]  cur_x_reg, cur_y_reg;
    logic [7:0]  cur_x_next, cur_y_next;

    // pending slot: registered font read plus the cursor it draws at
    logic        pend_reg;
    glyph_bits_t rom_q_reg;
    logic [7:0]  pend_x_reg, pend_y_reg;

    // pixel engine
    logic        busy_reg;
    logic [5:0]  k_reg;
    glyph_bits_t pat_reg;
    logic [7:0]  bx_reg, by_reg;

    logic        out_valid_reg;
    logic [7:0]  pix_x_reg, pix_y_reg;
    logic [2:0]  pix_color_reg;
    logic        last_reg;

    logic        in_fire, draw_fire, step, done_px, load;
    glyph_t      glyph_in;
    logic [7:0]  adv_x, adv_y;

    assign cfg_ready = 1'b1;
    assign in_ready  = !pend_reg;
    assign in_fire   = in_valid && in_ready;
    assign draw_fire = in_fire && (req_type == REQ_DRAW);
    assign glyph_in  = glyph_of(char_code);

    assign step    = busy_reg && (!out_valid_reg || out_ready);
    assign done_px = step && (k_reg == 6'd63);
    assign load    = pend_reg && (!busy_reg || done_px);

    // cursor advance after a draw
    always_comb
    begin
        adv_x = cur_x_reg + 8'd8;
        adv_y = cur_y_reg;
        if ({1'b0, adv_x} > X_LIMIT)
        begin
            adv_x = 8'd0;
            adv_y = cur_y_reg + 8'd8;
            if ({1'b0, adv_y} > Y_LIMIT)
                adv_y = 8'd0;
        end
    end

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (in_fire)
        begin
            if (req_type == REQ_MOVE)
            begin
                cur_x_next = move_x;
                cur_y_next = move_y;
            end
            else
            begin
                cur_x_next = adv_x;
                cur_y_next = adv_y;
            end
        end
    end

    // font ROM: one read of all eight rows of the glyph per draw
    always_ff @(posedge clk)
    begin
        if (draw_fire)
        begin
            for (int r = 0; r < 8; r++)
                rom_q_reg[r*8 +: 8] <= FONT_ROM[{glyph_in, 3'(r)}];
            pend_x_reg <= cur_x_reg;
            pend_y_reg <= cur_y_reg;
        end
        if (load)
        begin
            pat_reg <= rom_q_reg;
            bx_reg  <= pend_x_reg;
            by_reg  <= pend_y_reg;
        end
        if (step)
        begin
            pix_x_reg     <= bx_reg + {5'd0, k_reg[2:0]};
            pix_y_reg     <= by_reg + {5'd0, k_reg[5:3]};
            pix_color_reg <= pat_reg[k_reg] ? fg_reg : bg_reg;
            last_reg      <= (k_reg == 6'd63);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            cur_x_reg     <= 8'd0;
            cur_y_reg     <= 8'd0;
            pend_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            k_reg         <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FG_COLOR: fg_reg <= cfg_data;
                    CFG_BG_COLOR: bg_reg <= cfg_data;
                    default: ;
                endcase
            end

            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;

            if (draw_fire)
                pend_reg <= 1'b1;
            else if (load)
                pend_reg <= 1'b0;

            if (load)
                busy_reg <= 1'b1;
            else if (done_px)
                busy_reg <= 1'b0;

            if (step)
                k_reg <= k_reg + 6'd1;

            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign pix_color = pix_color_reg;
    assign last      = last_reg;

    // engine counter returns to zero whenever no glyph is in flight
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (k_reg == 6'd0))
        else $error("pixel counter nonzero while engine idle");

    // a draw transfer always lands in the pending slot
    a_draw_pend: assert property (@(posedge clk) disable iff (!rst_n)
        draw_fire |=> pend_reg)
        else $error("draw transfer lost");

    // an idle engine picks up a waiting glyph at once
    a_slot_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !busy_reg) |=> (busy_reg && !pend_reg && k_reg == 6'd0))
        else $error("pending glyph not loaded into idle engine");

    // a completed character always ends on its last pixel flag
    a_last_pix: assert property (@(posedge clk) disable iff (!rst_n)
        done_px |=> (out_valid_reg && last_reg))
        else $error("last pixel not flagged");

endmodule
